// File: hw/rtl/sector_cache_zero_coalescer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sector cache zero coalescer
// Concurrent checks that can be compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SECTOR_CACHE_ZERO_COALESCER_ASSERT_SVH
`define SECTOR_CACHE_ZERO_COALESCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, off while reset is asserted
`define SCZ_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("scz assertion failed");

// next-cycle implication, live through reset
`define SCZ_ASSERT_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("scz assertion failed");

`else

`define SCZ_ASSERT(lbl, clk, rst_n, ante, cons)
`define SCZ_ASSERT_NEXT(lbl, clk, ante, cons)

`endif

`endif

// File: hw/rtl/scz_pkg.sv
// ----------------------------------------------------------------------------
// scz_pkg
// Types and constants shared by the sector cache zero coalescer.
// ----------------------------------------------------------------------------
`default_nettype none

package scz_pkg;

    localparam int SECTOR_W   = 32;
    localparam int COUNT_W    = 16;
    localparam int RUN_W      = 32;
    localparam int SLOT_OUT_W = 6;
    localparam int CMDQ_DEPTH = 2;
    localparam int RESQ_DEPTH = 2;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_SYNC  = 2'd2,
        FUNC_CLEAR = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ACT_DONE       = 3'd0,
        ACT_ZEROS      = 3'd1,
        ACT_SERVE      = 3'd2,
        ACT_READ_FILL  = 3'd3,
        ACT_WRITE_FILL = 3'd4,
        ACT_ABSORB     = 3'd5
    } t_action;

    // tag work the back end performs after an optional run flush
    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_DONE   = 3'd1,
        CMD_READ   = 3'd2,
        CMD_WRITE  = 3'd3,
        CMD_ABSORB = 3'd4,
        CMD_CLEAR  = 3'd5
    } t_cmd_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_FLUSH,
        BK_SWEEP,
        BK_TAIL,
        BK_RESULT
    } t_back_state;

    typedef struct packed {
        t_cmd_op               op;
        logic                  flush;
        logic [SECTOR_W-1:0]   flush_sector;
        logic [RUN_W-1:0]      flush_count;
        logic [SECTOR_W-1:0]   sector;
        logic [COUNT_W-1:0]    count;
    } t_cmd;

    typedef struct packed {
        t_action               action;
        logic [SECTOR_W-1:0]   op_sector;
        logic [RUN_W-1:0]      op_count;
        logic [SLOT_OUT_W-1:0] slot;
        logic                  last;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/scz_fifo.sv
// ----------------------------------------------------------------------------
// scz_fifo
// Small register queue; push is dropped when full, pop ignored when empty.
// ----------------------------------------------------------------------------
`default_nettype none

module scz_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/scz_front.sv
// ----------------------------------------------------------------------------
// scz_front
// Request classifier: owns the pending zero run, decides flush and tag work.
// ----------------------------------------------------------------------------
`default_nettype none

module scz_front
    import scz_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire logic [1:0]          i_func,
    input  wire logic [SECTOR_W-1:0] i_start_sector,
    input  wire logic [COUNT_W-1:0]  i_sector_count,
    input  wire logic                i_data_all_zero,
    input  wire logic                i_q_full,
    output logic                     o_full,
    output logic                     o_cmd_push,
    output t_cmd                     o_cmd
);

    logic [SECTOR_W-1:0] r_run_start;
    logic [RUN_W-1:0]    r_run_len;
    logic [SECTOR_W-1:0] r_run_end;     // start + length, kept ahead of time
    logic [SECTOR_W-1:0] n_run_start;
    logic [RUN_W-1:0]    n_run_len;
    logic [SECTOR_W-1:0] n_run_end;

    logic                accept;
    logic                run_live;
    logic                contig;
    logic                overflow;
    logic                cnt_zero;
    logic [RUN_W-1:0]    cnt_ext;

    assign o_full     = i_q_full;
    assign accept     = i_push && !i_q_full;
    assign o_cmd_push = accept;

    assign cnt_ext  = RUN_W'(i_sector_count);
    assign cnt_zero = (i_sector_count == '0);
    assign run_live = (r_run_len != '0);
    assign contig   = !run_live || (i_start_sector == r_run_end);
    assign overflow = run_live && (r_run_len > ~cnt_ext);

    always_comb begin
        o_cmd              = '0;
        o_cmd.op           = CMD_DONE;
        o_cmd.flush_sector = r_run_start;
        o_cmd.flush_count  = r_run_len;
        o_cmd.sector       = i_start_sector;
        o_cmd.count        = i_sector_count;
        n_run_start        = r_run_start;
        n_run_len          = r_run_len;
        n_run_end          = r_run_end;

        case (t_func'(i_func))
            FUNC_READ: begin
                o_cmd.flush = run_live;
                o_cmd.op    = cnt_zero ? CMD_DONE : CMD_READ;
                n_run_len   = '0;
            end
            FUNC_WRITE: begin
                if (cnt_zero) begin
                    o_cmd.op = CMD_DONE;
                end else if (contig) begin
                    if (i_data_all_zero) begin
                        o_cmd.flush = overflow;
                        o_cmd.op    = CMD_ABSORB;
                        n_run_end   = i_start_sector + cnt_ext;
                        if (!run_live || overflow) begin
                            n_run_start = i_start_sector;
                            n_run_len   = cnt_ext;
                        end else begin
                            n_run_len = r_run_len + cnt_ext;
                        end
                    end else begin
                        o_cmd.op = CMD_WRITE;
                    end
                end else begin
                    o_cmd.flush = 1'b1;
                    o_cmd.op    = CMD_WRITE;
                    n_run_len   = '0;
                end
            end
            FUNC_SYNC: begin
                o_cmd.flush = run_live;
                o_cmd.op    = run_live ? CMD_NONE : CMD_DONE;
                n_run_len   = '0;
            end
            FUNC_CLEAR: begin
                o_cmd.op = CMD_CLEAR;
            end
            default: begin
                o_cmd.op = CMD_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_start <= '0;
            r_run_len   <= '0;
            r_run_end   <= '0;
        end else if (accept) begin
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_run_end   <= n_run_end;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/scz_back.sv
// ----------------------------------------------------------------------------
// scz_back
// Tag engine: flushes runs, sweeps the tag RAM one slot a cycle, fills slots.
// ----------------------------------------------------------------------------
`default_nettype none

module scz_back
    import scz_pkg::*;
#(
    parameter int CACHE_SLOTS = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_result   o_res
);

    localparam int SLOT_W = $clog2(CACHE_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CACHE_SLOTS - 1);

    t_back_state         r_state;
    t_back_state         n_state;
    t_cmd                r_cmd;

    logic [SECTOR_W-1:0] r_tag_mem [CACHE_SLOTS];
    logic [CACHE_SLOTS-1:0] r_valid;
    logic [SLOT_W-1:0]   r_next_slot;

    // sweep: read address, then in the next cycle the checked entry
    logic [SLOT_W-1:0]   r_idx;
    logic                r_chk_vld;
    logic [SLOT_W-1:0]   r_chk_idx;
    logic [SECTOR_W-1:0] r_rd_tag;
    logic                r_rd_vbit;
    logic                r_hit;
    logic [SLOT_W-1:0]   r_hit_idx;

    logic                rd_en;
    logic                fill;
    logic                clear_all;
    logic [SLOT_W-1:0]   fill_idx;
    logic                serve;

    logic                chk_nz;
    logic                chk_match;
    logic [SECTOR_W-1:0] chk_diff;
    logic                chk_in_range;
    logic                chk_inval;

    function automatic t_back_state work_state(input t_cmd_op op);
        t_back_state st;
        case (op)
            CMD_READ, CMD_WRITE, CMD_ABSORB: st = BK_SWEEP;
            CMD_DONE, CMD_CLEAR:             st = BK_RESULT;
            default:                         st = BK_IDLE;
        endcase
        return st;
    endfunction

    assign fill_idx = r_hit ? r_hit_idx : r_next_slot;
    assign serve    = r_hit && (r_cmd.count == COUNT_W'(1));

    assign chk_nz       = r_rd_vbit && (r_rd_tag != '0);
    assign chk_match    = chk_nz && (r_rd_tag == r_cmd.sector);
    assign chk_diff     = r_rd_tag - r_cmd.sector;
    assign chk_in_range = chk_nz && (chk_diff < SECTOR_W'(r_cmd.count));
    // a write keeps the first matching slot, which it then refills
    assign chk_inval    = ((r_cmd.op == CMD_ABSORB) && chk_in_range) ||
                          ((r_cmd.op == CMD_WRITE) && chk_in_range &&
                           !(chk_match && !r_hit));

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        o_res.last = 1'b1;
        rd_en      = 1'b0;
        fill       = 1'b0;
        clear_all  = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_state   = i_cmd.flush ? BK_FLUSH : work_state(i_cmd.op);
                end
            end
            BK_FLUSH: begin
                o_res.action    = ACT_ZEROS;
                o_res.op_sector = r_cmd.flush_sector;
                o_res.op_count  = r_cmd.flush_count;
                o_res.last      = (r_cmd.op == CMD_NONE);
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = work_state(r_cmd.op);
                end
            end
            BK_SWEEP: begin
                rd_en = 1'b1;
                if (r_idx == LAST_SLOT) begin
                    n_state = BK_TAIL;
                end
            end
            BK_TAIL: begin
                n_state = BK_RESULT;
            end
            BK_RESULT: begin
                case (r_cmd.op)
                    CMD_READ: begin
                        o_res.op_sector = r_cmd.sector;
                        if (serve) begin
                            o_res.action   = ACT_SERVE;
                            o_res.op_count = RUN_W'(1);
                            o_res.slot     = SLOT_OUT_W'(r_hit_idx);
                        end else begin
                            o_res.action   = ACT_READ_FILL;
                            o_res.op_count = RUN_W'(r_cmd.count);
                            o_res.slot     = SLOT_OUT_W'(fill_idx);
                        end
                    end
                    CMD_WRITE: begin
                        o_res.action    = ACT_WRITE_FILL;
                        o_res.op_sector = r_cmd.sector;
                        o_res.op_count  = RUN_W'(r_cmd.count);
                        o_res.slot      = SLOT_OUT_W'(fill_idx);
                    end
                    CMD_ABSORB: begin
                        o_res.action    = ACT_ABSORB;
                        o_res.op_sector = r_cmd.sector;
                        o_res.op_count  = RUN_W'(r_cmd.count);
                    end
                    default: begin
                        o_res.action = ACT_DONE;
                    end
                endcase
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    fill       = ((r_cmd.op == CMD_READ) && !serve) ||
                                 (r_cmd.op == CMD_WRITE);
                    clear_all  = (r_cmd.op == CMD_CLEAR);
                    n_state    = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_chk_vld   <= 1'b0;
            r_valid     <= '0;
            r_next_slot <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_chk_vld <= rd_en;
            if (o_cmd_pop) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (rd_en) begin
                r_idx <= (r_idx == LAST_SLOT) ? '0 : r_idx + 1'b1;
            end
            if (r_chk_vld) begin
                if (chk_match && !r_hit) begin
                    r_hit <= 1'b1;
                end
                if (chk_inval) begin
                    r_valid[r_chk_idx] <= 1'b0;
                end
            end
            if (fill) begin
                r_valid[fill_idx] <= 1'b1;
                r_next_slot       <= (fill_idx == LAST_SLOT) ? '0 : fill_idx + 1'b1;
            end
            if (clear_all) begin
                r_valid <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_chk_vld && chk_match && !r_hit) begin
            r_hit_idx <= r_chk_idx;
        end
        r_chk_idx <= r_idx;
        r_rd_vbit <= r_valid[r_idx];
    end

    // tag RAM: one read port for the sweep, one write port for fills
    always_ff @(posedge i_clk) begin
        if (fill) begin
            r_tag_mem[fill_idx] <= r_cmd.sector;
        end
        if (rd_en) begin
            r_rd_tag <= r_tag_mem[r_idx];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/sector_cache_zero_coalescer.sv
// ----------------------------------------------------------------------------
// sector_cache_zero_coalescer
// Tag and policy engine of a round-robin sector cache with zero-run merging.
// ----------------------------------------------------------------------------
//  channel   handshake           payload
//  request   i_push / o_full     i_func, i_start_sector, i_sector_count,
//                                i_data_all_zero
//  result    o_empty / i_pop     o_action, o_op_sector, o_op_count, o_slot,
//                                o_last
//
//  Reads, writes and absorbed writes sweep the tag RAM one slot per cycle,
//  then pass a tail state before the result, after a flush state if a run is flushed.
//  Sync, clear and zero-count requests skip the sweep.
//  Reset is synchronous; tag valid bits clear at once, no clearing pass.
//  Two requests may wait in the command queue; a flush or result beat stalls
//  while the result queue is full; o_full rises once the command queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sector_cache_zero_coalescer_assert.svh"

module sector_cache_zero_coalescer
    import scz_pkg::*;
#(
    parameter int CACHE_SLOTS = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    output logic                       o_full,
    input  wire logic [1:0]            i_func,
    input  wire logic [SECTOR_W-1:0]   i_start_sector,
    input  wire logic [COUNT_W-1:0]    i_sector_count,
    input  wire logic                  i_data_all_zero,
    output logic                       o_empty,
    input  wire logic                  i_pop,
    output logic [2:0]                 o_action,
    output logic [SECTOR_W-1:0]        o_op_sector,
    output logic [RUN_W-1:0]           o_op_count,
    output logic [SLOT_OUT_W-1:0]      o_slot,
    output logic                       o_last
);

    t_cmd    front_cmd;
    logic    front_push;
    logic    cmdq_full;
    logic    cmdq_empty;
    t_cmd    cmdq_head;
    logic    cmd_pop;
    t_result back_res;
    logic    back_push;
    logic    resq_full;
    t_result resq_head;

    scz_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (i_push),
        .i_func          (i_func),
        .i_start_sector  (i_start_sector),
        .i_sector_count  (i_sector_count),
        .i_data_all_zero (i_data_all_zero),
        .i_q_full        (cmdq_full),
        .o_full          (o_full),
        .o_cmd_push      (front_push),
        .o_cmd           (front_cmd)
    );

    scz_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_cmd),
        .o_full  (cmdq_full),
        .i_pop   (cmd_pop),
        .o_empty (cmdq_empty),
        .o_data  (cmdq_head)
    );

    scz_back #(
        .CACHE_SLOTS (CACHE_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (!cmdq_empty),
        .i_cmd       (cmdq_head),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (resq_full),
        .o_res_push  (back_push),
        .o_res       (back_res)
    );

    scz_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RESQ_DEPTH)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_push),
        .i_data  (back_res),
        .o_full  (resq_full),
        .i_pop   (i_pop),
        .o_empty (o_empty),
        .o_data  (resq_head)
    );

    assign o_action    = resq_head.action;
    assign o_op_sector = resq_head.op_sector;
    assign o_op_count  = resq_head.op_count;
    assign o_slot      = resq_head.slot;
    assign o_last      = resq_head.last;

    // only a run flush can precede another beat of the same request
    `SCZ_ASSERT(a_nonlast_is_flush, i_clk, i_rst_n, !o_empty && !o_last, o_action == ACT_ZEROS)
    `SCZ_ASSERT(a_done_is_clean, i_clk, i_rst_n, !o_empty && o_action == ACT_DONE, o_op_sector == '0 && o_op_count == '0 && o_slot == '0)
    `SCZ_ASSERT(a_serve_single, i_clk, i_rst_n, !o_empty && o_action == ACT_SERVE, o_op_count == 32'd1)
    `SCZ_ASSERT_NEXT(a_reset_clears_queues, i_clk, !i_rst_n, o_empty && !o_full)

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sector cache zero coalescer. A policy model of
// the tag array, round-robin pointer and pending zero run predicts the result
// beats of every accepted request; a checker compares each popped beat with
// the oldest prediction. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module tb;
    import scz_pkg::*;

    localparam int SLOTS       = 64;
    localparam int RANDOM_REQS = 550;
    localparam int TAIL_CYCLES = SLOTS + 16;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_push          = 1'b0;
    t_func                 i_func          = FUNC_READ;
    logic [SECTOR_W-1:0]   i_start_sector  = '0;
    logic [COUNT_W-1:0]    i_sector_count  = '0;
    logic                  i_data_all_zero = 1'b0;
    logic                  i_pop           = 1'b0;
    logic                  o_full;
    logic                  o_empty;
    logic [2:0]            o_action;
    logic [SECTOR_W-1:0]   o_op_sector;
    logic [RUN_W-1:0]      o_op_count;
    logic [SLOT_OUT_W-1:0] o_slot;
    logic                  o_last;

    int errors    = 0;
    int reqs_sent = 0;
    bit calm      = 1'b0;

    // policy model state
    logic [SECTOR_W-1:0] tag_mem [SLOTS] = '{default: '0};
    int                  fill_ptr = 0;
    logic [SECTOR_W-1:0] run_base = '0;
    logic [RUN_W-1:0]    run_len  = '0;
    t_result             expected_ops [$];

    sector_cache_zero_coalescer #(
        .CACHE_SLOTS(SLOTS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push),
        .o_full         (o_full),
        .i_func         (i_func),
        .i_start_sector (i_start_sector),
        .i_sector_count (i_sector_count),
        .i_data_all_zero(i_data_all_zero),
        .o_empty        (o_empty),
        .i_pop          (i_pop),
        .o_action       (o_action),
        .o_op_sector    (o_op_sector),
        .o_op_count     (o_op_count),
        .o_slot         (o_slot),
        .o_last         (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic void queue_result(t_action act, logic [SECTOR_W-1:0] sec,
                                         logic [RUN_W-1:0] cnt, int s, logic fin);
        t_result r;
        r.action    = act;
        r.op_sector = sec;
        r.op_count  = cnt;
        r.slot      = SLOT_OUT_W'(s);
        r.last      = fin;
        expected_ops.push_back(r);
    endfunction

    function automatic void flush_zero_run(logic fin);
        queue_result(ACT_ZEROS, run_base, run_len, 0, fin);
        run_len = '0;
    endfunction

    // clear tags falling in [sec, sec + cnt), wrapping at 2^32
    function automatic void drop_stale_tags(logic [SECTOR_W-1:0] sec,
                                            logic [COUNT_W-1:0] cnt, int keep);
        logic [SECTOR_W-1:0] offset;
        for (int i = 0; i < SLOTS; i++) begin
            offset = tag_mem[i] - sec;
            if (i != keep && tag_mem[i] != '0 && offset < {16'd0, cnt})
                tag_mem[i] = '0;
        end
    endfunction

    function automatic int lookup_tag(logic [SECTOR_W-1:0] sec);
        if (sec != '0) begin
            for (int i = 0; i < SLOTS; i++)
                if (tag_mem[i] == sec)
                    return i;
        end
        return -1;
    endfunction

    function automatic int allocate_slot(logic [SECTOR_W-1:0] sec);
        int s;
        s = lookup_tag(sec);
        if (s < 0)
            s = fill_ptr;
        tag_mem[s] = sec;
        fill_ptr   = (s + 1) % SLOTS;
        return s;
    endfunction

    function automatic void predict_cache_actions(t_func f, logic [SECTOR_W-1:0] sec,
                                                  logic [COUNT_W-1:0] cnt, logic zero);
        int  s;
        bit  absorbed;
        logic [SECTOR_W-1:0] run_end;
        run_end  = run_base + run_len;
        absorbed = 1'b0;
        case (f)
            FUNC_READ: begin
                if (run_len != '0)
                    flush_zero_run(1'b0);
                if (cnt == '0) begin
                    queue_result(ACT_DONE, '0, '0, 0, 1'b1);
                end else begin
                    s = (cnt == 1) ? lookup_tag(sec) : -1;
                    if (s >= 0) begin
                        queue_result(ACT_SERVE, sec, 1, s, 1'b1);
                    end else begin
                        s = allocate_slot(sec);
                        queue_result(ACT_READ_FILL, sec, RUN_W'(cnt), s, 1'b1);
                    end
                end
            end
            FUNC_WRITE: begin
                if (cnt == '0) begin
                    queue_result(ACT_DONE, '0, '0, 0, 1'b1);
                end else begin
                    if (run_len == '0 || sec == run_end) begin
                        if (zero) begin
                            if (run_len != '0 && run_len > 32'hFFFF_FFFF - RUN_W'(cnt))
                                flush_zero_run(1'b0);
                            if (run_len == '0)
                                run_base = sec;
                            run_len = run_len + RUN_W'(cnt);
                            drop_stale_tags(sec, cnt, -1);
                            queue_result(ACT_ABSORB, sec, RUN_W'(cnt), 0, 1'b1);
                            absorbed = 1'b1;
                        end
                    end else begin
                        flush_zero_run(1'b0);
                    end
                    if (!absorbed) begin
                        s = allocate_slot(sec);
                        drop_stale_tags(sec, cnt, s);
                        queue_result(ACT_WRITE_FILL, sec, RUN_W'(cnt), s, 1'b1);
                    end
                end
            end
            FUNC_SYNC: begin
                if (run_len != '0)
                    flush_zero_run(1'b1);
                else
                    queue_result(ACT_DONE, '0, '0, 0, 1'b1);
            end
            default: begin
                foreach (tag_mem[i])
                    tag_mem[i] = '0;
                queue_result(ACT_DONE, '0, '0, 0, 1'b1);
            end
        endcase
    endfunction

    // holds push high until the beat is taken; push is only lowered in a gap
    task automatic issue_request(t_func f, logic [SECTOR_W-1:0] sec,
                                 logic [COUNT_W-1:0] cnt, logic zero);
        while (!calm && $urandom_range(99) < 15) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push          <= 1'b1;
        i_func          <= f;
        i_start_sector  <= sec;
        i_sector_count  <= cnt;
        i_data_all_zero <= zero;
        @(posedge i_clk);
        while (o_full)
            @(posedge i_clk);
        predict_cache_actions(f, sec, cnt, zero);
        reqs_sent++;
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
        end
    endfunction

    initial begin
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && i_pop && !o_empty) begin
                if (expected_ops.size() == 0) begin
                    errors++;
                    $display("%0t: beat with nothing expected: action %0d sector %h count %h",
                             $time, o_action, o_op_sector, o_op_count);
                end else begin
                    want = expected_ops.pop_front();
                    check_field("action", 32'(want.action), 32'(o_action));
                    check_field("op_sector", want.op_sector, o_op_sector);
                    check_field("op_count", want.op_count, o_op_count);
                    check_field("slot", 32'(want.slot), 32'(o_slot));
                    check_field("last", 32'(want.last), 32'(o_last));
                end
            end
            i_pop <= i_rst_n && (calm || $urandom_range(99) >= 15);
        end
    end

    function automatic logic [SECTOR_W-1:0] pick_sector();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return $urandom_range(95);
        if (r < 85)
            return 32'hFFFF_FF80 + $urandom_range(127);
        return $urandom();
    endfunction

    function automatic logic [COUNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return COUNT_W'(1);
        if (r < 80)
            return COUNT_W'($urandom_range(8, 2));
        if (r < 88)
            return '0;
        return COUNT_W'($urandom_range(65535));
    endfunction

    // zero counts answer done; sector 0 fills an empty tag and never hits
    task automatic test_zero_count();
        issue_request(FUNC_READ, 32'h0000_0005, 0, 1'b0);
        issue_request(FUNC_WRITE, 32'h0000_0005, 0, 1'b1);
        issue_request(FUNC_READ, 32'h0000_0000, 1, 1'b0);
        issue_request(FUNC_READ, 32'h0000_0000, 1, 1'b1);
    endtask

    task automatic test_read_hit();
        issue_request(FUNC_READ, 32'h0000_0010, 1, 1'b0);
        issue_request(FUNC_READ, 32'h0000_0010, 1, 1'b0);
        issue_request(FUNC_READ, 32'h0000_0010, 4, 1'b0);
        issue_request(FUNC_READ, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
    endtask

    task automatic test_zero_runs();
        issue_request(FUNC_WRITE, 32'h0000_0020, 3, 1'b1);
        issue_request(FUNC_WRITE, 32'h0000_0023, 2, 1'b1);
        issue_request(FUNC_WRITE, 32'h0000_0025, 1, 1'b0);   // run stays pending
        issue_request(FUNC_WRITE, 32'h0000_0010, 1, 1'b1);   // flush, then device write
        issue_request(FUNC_WRITE, 32'h0000_0040, 2, 1'b1);
        issue_request(FUNC_READ, 32'h0000_0041, 1, 1'b0);
    endtask

    task automatic test_write_invalidate();
        issue_request(FUNC_READ, 32'h0000_0080, 1, 1'b0);
        issue_request(FUNC_WRITE, 32'h0000_007E, 4, 1'b1);
        issue_request(FUNC_READ, 32'h0000_0080, 1, 1'b0);
        issue_request(FUNC_WRITE, 32'h0000_007F, 2, 1'b0);
    endtask

    task automatic test_sync_clear();
        issue_request(FUNC_SYNC, 32'h0000_0000, 0, 1'b0);
        issue_request(FUNC_WRITE, 32'hFFFF_FFF0, 16'h0020, 1'b1);   // run wraps past 2^32
        issue_request(FUNC_WRITE, 32'h0000_0010, 1, 1'b1);
        issue_request(FUNC_SYNC, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        issue_request(FUNC_READ, 32'h0000_0010, 1, 1'b0);
        issue_request(FUNC_CLEAR, 32'h0000_0000, 0, 1'b0);
        issue_request(FUNC_READ, 32'h0000_0010, 1, 1'b0);
    endtask

    task automatic test_random();
        int                 base;
        int                 kind;
        int                 n;
        logic [SECTOR_W-1:0] sec;
        logic [COUNT_W-1:0]  cnt;
        base = reqs_sent;
        while (reqs_sent < base + RANDOM_REQS) begin
            calm <= (reqs_sent - base >= 200) && (reqs_sent - base < 300);
            kind = $urandom_range(99);
            if (kind < 35) begin
                // zero run with random content, then often something that ends or breaks it
                n   = $urandom_range(6, 1);
                sec = (run_len != '0 && $urandom_range(1)) ? run_base + run_len
                                                           : pick_sector();
                for (int k = 0; k < n; k++) begin
                    cnt = COUNT_W'($urandom_range(8, 1));
                    issue_request(FUNC_WRITE, sec, cnt, $urandom_range(99) >= 20);
                    sec = (run_len != '0) ? run_base + run_len : sec + SECTOR_W'(cnt);
                end
                case ($urandom_range(3))
                    0: issue_request(FUNC_SYNC, $urandom(), 16'($urandom()),
                                     1'($urandom_range(1)));
                    1: issue_request(FUNC_READ, run_base + $urandom_range(7), 1, 1'b0);
                    2: issue_request(FUNC_WRITE, pick_sector(), pick_count(),
                                     1'($urandom_range(1)));
                    default: ;
                endcase
            end else if (kind < 65) begin
                issue_request(FUNC_READ, pick_sector(), pick_count(), 1'($urandom_range(1)));
            end else if (kind < 85) begin
                issue_request(FUNC_WRITE, pick_sector(), pick_count(), $urandom_range(99) < 30);
            end else if (kind < 90) begin
                issue_request(FUNC_SYNC, pick_sector(), pick_count(), 1'($urandom_range(1)));
            end else if (kind < 93) begin
                issue_request(FUNC_CLEAR, pick_sector(), pick_count(), 1'($urandom_range(1)));
            end else begin
                issue_request(t_func'($urandom_range(3)), $urandom(), 16'($urandom()),
                              1'($urandom_range(1)));
            end
        end
        calm <= 1'b0;
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_zero_count();
        test_read_hit();
        test_zero_runs();
        test_write_invalidate();
        test_sync_clear();
        test_random();
        i_push <= 1'b0;
        wait (expected_ops.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_ops.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
